@@ rtl/core/pgbs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pgbs_pkg: shared definitions for the projectile gravity and bounce step core
// Command, status and register codes, field widths and the rounding helper.
// ----------------------------------------------------------------------------
package pgbs_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NORM_W   = 16;
    localparam int unsigned BUDGET_W = 7;
    localparam int unsigned GRAV_W   = 12;
    localparam int unsigned BOUNCE_W = 8;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // Input tdata: seven words, three normals, the solid flag, padded to bytes.
    localparam int unsigned IN_DATA_W  = 280;
    localparam int unsigned OUT_DATA_W = 288;

    localparam int unsigned DOT_SHIFT  = 11;
    localparam int unsigned NORM_SHIFT = 12;
    localparam int unsigned IMP_SHIFT  = 7;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONTACT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPAWN   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BOUNCED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXPIRED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IMPULSE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV   = 1'b1;

    localparam logic [BUDGET_W-1:0] BUDGET_RST = 7'd3;
    localparam logic [GRAV_W-1:0]   GRAV_RST   = 12'h05a;

    typedef logic [WORD_W-1:0] t_word;

    // Signed divide by 2^k, rounded toward zero: bias negatives, then shift.
    function automatic t_word f_div_pow2(input t_word v, input int unsigned k);
        t_word bias;
        t_word sum;
        bias = v[WORD_W-1] ? ((t_word'(1) << k) - t_word'(1)) : '0;
        sum  = v + bias;
        return t_word'($signed(sum) >>> k);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/projectile_gravity_bounce_step_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// projectile_gravity_bounce_step_core: single projectile integrator
// Spawn, gravity tick with terrain bounce, and contact impulse response.
// ----------------------------------------------------------------------------
// The core holds one projectile (position, velocity, bounce counter) and takes
// one command transaction at a time on the slave stream; each command returns
// exactly one result transaction with the full state after the command, a
// status code and the impulse (zero unless the status says impulse issued).
// A spawn, an ignored contact or an unused command goes straight to the result
// state; a tick first runs the gravity step and the bounce check, and a contact
// against a solid target runs the dot product terms and their scaling, then the
// three velocity corrections only when the dot product comes out negative. The
// slave side is ready again on the cycle after the result is loaded.
// Contacts use the one 32x16 multiplier, which serves the three dot product
// terms and then the three correction products in turn, with a register
// after every product. The slave side is ready only while the sequencer
// is idle; a finished result sits in the output register, so the next
// command is taken while the previous result still waits.
// Configuration writes (bounce budget, gravity step) are taken at any edge
// with the write enable high and should only be issued while the core is idle.

module projectile_gravity_bounce_step_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Configuration write port.
    input  wire                              i_cfg_we,
    input  wire [pgbs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [pgbs_pkg::GRAV_W-1:0]       i_cfg_data,
    // Command stream.
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata from bit 0 up: spawn_pos_x, spawn_pos_y, spawn_pos_z, spawn_vel_x,
    // spawn_vel_y, spawn_vel_z, ground_height, normal_x, normal_y, normal_z,
    // target_solid, zero padding.
    input  wire [pgbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser from bit 0 up: cmd.
    input  wire [pgbs_pkg::CMD_W-1:0]        s_axis_tuser,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // tdata from bit 0 up: out_pos_x, out_pos_y, out_pos_z, out_vel_x,
    // out_vel_y, out_vel_z, impulse_x, impulse_y, impulse_z.
    output logic [pgbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser from bit 0 up: status.
    output logic [pgbs_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import pgbs_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TICK   = 4'd1;
    localparam logic [3:0] S_BOUNCE = 4'd2;
    localparam logic [3:0] S_DOT0   = 4'd3;
    localparam logic [3:0] S_DOT1   = 4'd4;
    localparam logic [3:0] S_DOT2   = 4'd5;
    localparam logic [3:0] S_DOT3   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_CX     = 4'd8;
    localparam logic [3:0] S_CY     = 4'd9;
    localparam logic [3:0] S_CZ     = 4'd10;
    localparam logic [3:0] S_CW     = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Configuration registers.
    logic [BUDGET_W-1:0] r_budget;
    logic [GRAV_W-1:0]   r_grav;

    // Projectile state.
    t_word r_pos_x, r_pos_y, r_pos_z;
    t_word r_vel_x, r_vel_y, r_vel_z;
    logic [BOUNCE_W-1:0] r_bounces;

    // Per-command working registers.
    t_word r_ground;
    logic [NORM_W-1:0] r_nx, r_ny, r_nz;
    t_word r_prod;
    t_word r_acc;
    t_word r_dot;
    t_word r_imp_x, r_imp_y, r_imp_z;
    logic [STATUS_W-1:0] r_status;

    // Result register.
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [STATUS_W-1:0]   r_m_user;

    // Shared multiplier operands and product (low 32 bits).
    t_word             w_mul_a;
    logic [NORM_W-1:0] w_mul_b;
    t_word             w_mul_y;

    // Bounce decision.
    logic              w_hit;
    logic [BOUNCE_W-1:0] w_bounces_dec;
    t_word             w_dot;
    logic              w_accept;
    logic              w_out_free;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // The multiplier is steered by the sequencer: dot product terms first,
    // then the dot times each normal component.
    always_comb begin
        case (r_state)
            S_DOT0: begin
                w_mul_a = r_vel_x;
                w_mul_b = r_nx;
            end
            S_DOT1: begin
                w_mul_a = r_vel_y;
                w_mul_b = r_ny;
            end
            S_DOT2: begin
                w_mul_a = r_vel_z;
                w_mul_b = r_nz;
            end
            S_CX: begin
                w_mul_a = r_dot;
                w_mul_b = r_nx;
            end
            S_CY: begin
                w_mul_a = r_dot;
                w_mul_b = r_ny;
            end
            S_CZ: begin
                w_mul_a = r_dot;
                w_mul_b = r_nz;
            end
            default: begin
                w_mul_a = r_vel_x;
                w_mul_b = r_nx;
            end
        endcase
    end

    assign w_mul_y = w_mul_a * {{(WORD_W-NORM_W){w_mul_b[NORM_W-1]}}, w_mul_b};

    // A bounce needs a downward (positive) velocity and a height past the
    // terrain; y grows downward so "past" is a signed greater-than.
    assign w_hit = !r_vel_y[WORD_W-1] && (r_vel_y != '0) &&
                   ($signed(r_pos_y) > $signed(r_ground));
    assign w_bounces_dec = r_bounces - BOUNCE_W'(1);

    assign w_dot = f_div_pow2(r_acc, DOT_SHIFT);

    always_comb begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (s_axis_tuser)
                        CMD_TICK:    n_state = S_TICK;
                        CMD_CONTACT: n_state = s_axis_tdata[272] ? S_DOT0 : S_DONE;
                        default:     n_state = S_DONE;
                    endcase
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TICK:   n_state = S_BOUNCE;
            S_BOUNCE: n_state = S_DONE;
            S_DOT0:   n_state = S_DOT1;
            S_DOT1:   n_state = S_DOT2;
            S_DOT2:   n_state = S_DOT3;
            S_DOT3:   n_state = S_DIV;
            S_DIV:    n_state = w_dot[WORD_W-1] ? S_CX : S_DONE;
            S_CX:     n_state = S_CY;
            S_CY:     n_state = S_CZ;
            S_CZ:     n_state = S_CW;
            S_CW:     n_state = S_DONE;
            S_DONE:   n_state = w_out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_budget  <= BUDGET_RST;
            r_grav    <= GRAV_RST;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_pos_z   <= '0;
            r_vel_x   <= '0;
            r_vel_y   <= '0;
            r_vel_z   <= '0;
            r_bounces <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUDGET: r_budget <= i_cfg_data[BUDGET_W-1:0];
                    CFG_GRAV:   r_grav   <= i_cfg_data;
                    default:    r_grav   <= r_grav;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept && (s_axis_tuser == CMD_SPAWN)) begin
                        r_pos_x   <= s_axis_tdata[31:0];
                        r_pos_y   <= s_axis_tdata[63:32];
                        r_pos_z   <= s_axis_tdata[95:64];
                        r_vel_x   <= s_axis_tdata[127:96];
                        r_vel_y   <= s_axis_tdata[159:128];
                        r_vel_z   <= s_axis_tdata[191:160];
                        r_bounces <= {1'b0, r_budget};
                    end
                end
                S_TICK: begin
                    r_pos_x <= r_pos_x + r_vel_x;
                    r_pos_y <= r_pos_y + r_vel_y;
                    r_pos_z <= r_pos_z + r_vel_z;
                    r_vel_y <= r_vel_y + {{(WORD_W-GRAV_W){1'b0}}, r_grav};
                end
                S_BOUNCE: begin
                    if (w_hit) begin
                        // Negated and halved toward zero; the velocity is
                        // positive here, so this is minus half its magnitude.
                        r_pos_y   <= r_ground;
                        r_bounces <= w_bounces_dec;
                        r_vel_y   <= t_word'(0) - {1'b0, r_vel_y[WORD_W-1:1]};
                    end
                end
                S_CY: r_vel_x <= r_vel_x - f_div_pow2(r_prod, NORM_SHIFT);
                S_CZ: r_vel_y <= r_vel_y - f_div_pow2(r_prod, NORM_SHIFT);
                S_CW: r_vel_z <= r_vel_z - f_div_pow2(r_prod, NORM_SHIFT);
                default: begin
                    r_pos_x <= r_pos_x;
                end
            endcase

            if ((r_state == S_DONE) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Working registers and the result payload; no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_y;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_status <= ST_NONE;
                    r_imp_x  <= '0;
                    r_imp_y  <= '0;
                    r_imp_z  <= '0;
                    r_ground <= s_axis_tdata[223:192];
                    r_nx     <= s_axis_tdata[239:224];
                    r_ny     <= s_axis_tdata[255:240];
                    r_nz     <= s_axis_tdata[271:256];
                end
            end
            S_BOUNCE: begin
                if (w_hit) begin
                    r_status <= (w_bounces_dec == '0) ? ST_EXPIRED : ST_BOUNCED;
                end
            end
            S_DOT1: r_acc <= r_prod;
            S_DOT2: r_acc <= r_acc + r_prod;
            S_DOT3: r_acc <= r_acc + r_prod;
            S_DIV: begin
                r_dot <= w_dot;
                if (w_dot[WORD_W-1]) begin
                    // Impulse uses the velocity from before the correction.
                    r_status <= ST_IMPULSE;
                    r_imp_x  <= r_vel_x << IMP_SHIFT;
                    r_imp_y  <= r_vel_y << IMP_SHIFT;
                    r_imp_z  <= r_vel_z << IMP_SHIFT;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_m_data <= {r_imp_z, r_imp_y, r_imp_x,
                                 r_vel_z, r_vel_y, r_vel_x,
                                 r_pos_z, r_pos_y, r_pos_x};
                    r_m_user <= r_status;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // The core takes one command and then drops ready before taking another.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while previous one still in progress");

    // A new result only appears out of the final sequencer state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the completion state");

    // The correction pass only runs on a negative dot product.
    a_corr_needs_neg_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CX) |-> r_dot[WORD_W-1])
        else $error("normal correction started with non-negative dot product");

    // Impulse fields are zero unless an impulse is reported.
    a_impulse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_IMPULSE) |->
            (m_axis_tdata[OUT_DATA_W-1:192] == '0))
        else $error("impulse reported without impulse status");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the projectile gravity and bounce step core
// Drives spawn, tick, contact and unused commands on the command stream.
// An in-bench projectile model predicts every result. Results are compared
// field by field as they leave the core, under varied stall patterns and
// bounce budget and gravity settings.
// ----------------------------------------------------------------------------

module tb_top;

    import pgbs_pkg::*;

    // The package names only the three live commands; code 3 must do nothing.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 10;
    // The slowest command is a contact with correction.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 390;

    // One command transaction, in the order the fields sit in tdata.
    typedef struct packed {
        logic              solid;
        logic [2:0][15:0]  nrm;
        logic [31:0]       ground;
        logic [2:0][31:0]  vel;
        logic [2:0][31:0]  pos;
        logic [CMD_W-1:0]  cmd;
    } t_projectile_cmd;

    // One result transaction: state after the command, impulse and status.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [2:0][31:0]    imp;
        logic [2:0][31:0]    vel;
        logic [2:0][31:0]    pos;
    } t_step_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [GRAV_W-1:0]         i_cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_W-1:0]      s_axis_tdata;
    logic [CMD_W-1:0]          s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_DATA_W-1:0]     m_axis_tdata;
    logic [STATUS_W-1:0]       m_axis_tuser;

    projectile_gravity_bounce_step_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // Fields from bit 0 up: spawn_pos_x/y/z, spawn_vel_x/y/z, ground_height,
        // normal_x/y/z, target_solid, zero padding.
        .s_axis_tdata (s_axis_tdata),
        // Fields from bit 0 up: cmd.
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // Fields from bit 0 up: out_pos_x/y/z, out_vel_x/y/z, impulse_x/y/z.
        .m_axis_tdata (m_axis_tdata),
        // Fields from bit 0 up: status.
        .m_axis_tuser (m_axis_tuser)
    );

    // Projectile model: its own copy of the core state and registers.
    logic [2:0][31:0]   proj_pos;
    logic [2:0][31:0]   proj_vel;
    logic [7:0]         bounces_left;
    logic [BUDGET_W-1:0] budget_reg;
    logic [GRAV_W-1:0]  grav_step;

    // Results predicted for accepted commands, oldest first.
    t_step_result expected_steps[$];

    // Chance, in percent, that the command side idles or the result side stalls.
    int src_idle_pct;
    int snk_stall_pct;

    int mismatch_cnt;
    int sent_cnt;
    int result_cnt;
    int bounce_cnt;
    int expire_cnt;
    int impulse_cnt;
    int cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a healthy run ends far below this cycle count.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still due",
                 cycle_cnt, expected_steps.size());
        $display("tb: failure");
        $finish;
    end

    // Signed divide by a power of two that rounds toward zero, as the core does
    // for the bounce halving and both contact scalings.
    function automatic logic [31:0] shift_toward_zero(input logic [31:0] v,
                                                      input int k);
        logic [31:0] mag;
        if (v[31]) begin
            mag = 32'd0 - v;
            return 32'd0 - (mag >> k);
        end
        return v >> k;
    endfunction

    // Applies one accepted command to the model and returns the result the core
    // must produce for it.
    function automatic t_step_result advance_projectile(input t_projectile_cmd c);
        t_step_result     r;
        logic [2:0][31:0] nrm_ext;
        logic [31:0]      dot;
        int               i;
        r = '0;
        r.status = ST_NONE;
        case (c.cmd)
            CMD_SPAWN: begin
                proj_pos     = c.pos;
                proj_vel     = c.vel;
                bounces_left = {1'b0, budget_reg};
            end
            CMD_TICK: begin
                for (i = 0; i < 3; i++)
                    proj_pos[i] = proj_pos[i] + proj_vel[i];
                proj_vel[1] = proj_vel[1] + {20'd0, grav_step};
                // Falling (positive y velocity) and now below the terrain.
                if (!proj_vel[1][31] && proj_vel[1] != 32'd0 &&
                    $signed(proj_pos[1]) > $signed(c.ground)) begin
                    proj_pos[1]  = c.ground;
                    bounces_left = bounces_left - 8'd1;
                    proj_vel[1]  = shift_toward_zero(32'd0 - proj_vel[1], 1);
                    if (bounces_left == 8'd0) begin
                        r.status = ST_EXPIRED;
                        expire_cnt++;
                    end else begin
                        r.status = ST_BOUNCED;
                        bounce_cnt++;
                    end
                end
            end
            CMD_CONTACT: begin
                if (c.solid) begin
                    for (i = 0; i < 3; i++)
                        nrm_ext[i] = {{16{c.nrm[i][15]}}, c.nrm[i]};
                    dot = proj_vel[0] * nrm_ext[0] + proj_vel[1] * nrm_ext[1] +
                          proj_vel[2] * nrm_ext[2];
                    dot = shift_toward_zero(dot, DOT_SHIFT);
                    // Only a velocity heading into the surface is reflected.
                    if (dot[31]) begin
                        for (i = 0; i < 3; i++) begin
                            r.imp[i]    = proj_vel[i] << IMP_SHIFT;
                            proj_vel[i] = proj_vel[i] -
                                          shift_toward_zero(dot * nrm_ext[i], NORM_SHIFT);
                        end
                        r.status = ST_IMPULSE;
                        impulse_cnt++;
                    end
                end
            end
            default: begin
            end
        endcase
        r.pos = proj_pos;
        r.vel = proj_vel;
        return r;
    endfunction

    // Word values spread over small magnitudes, wide magnitudes and the corners.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(4000) - 2000;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'hffff_ffff;
                    default: return 32'd0;
                endcase
            end
            default: return $urandom_range(400000) - 200000;
        endcase
    endfunction

    // Normals: mostly near unit length in 4.12, sometimes any code or a corner.
    function automatic logic [15:0] rand_normal();
        case ($urandom_range(3))
            0: return 16'($urandom());
            1: begin
                case ($urandom_range(3))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'h1000;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'($urandom_range(8192) - 4096);
        endcase
    endfunction

    // Random command with all fields filled. Half of the ticks put the terrain
    // just around the next height so that bounces are frequent.
    function automatic t_projectile_cmd random_command();
        t_projectile_cmd c;
        logic [31:0]     next_y;
        int              pick;
        int              i;
        for (i = 0; i < 3; i++) begin
            c.pos[i] = rand_word();
            c.vel[i] = rand_word();
            c.nrm[i] = rand_normal();
        end
        c.ground = rand_word();
        c.solid  = ($urandom_range(99) < 85);
        pick     = $urandom_range(99);
        if (pick < 12) begin
            c.cmd = CMD_SPAWN;
        end else if (pick < 62) begin
            c.cmd = CMD_TICK;
            if ($urandom_range(1) == 1) begin
                next_y   = proj_pos[1] + proj_vel[1];
                c.ground = next_y - ($urandom_range(400) - 100);
            end
        end else if (pick < 94) begin
            c.cmd = CMD_CONTACT;
        end else begin
            c.cmd = CMD_UNUSED;
        end
        return c;
    endfunction

    // Presents one command, waits for its transaction and records the
    // predicted result. Called at a rising edge; leaves at the accepting edge.
    task automatic send_command(input t_projectile_cmd c);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, c.solid, c.nrm, c.ground, c.vel, c.pos};
        s_axis_tuser  <= c.cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        expected_steps.push_back(advance_projectile(c));
        sent_cnt++;
    endtask

    task automatic send_spawn(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [31:0] vx,
                              input logic [31:0] vy, input logic [31:0] vz);
        t_projectile_cmd c;
        c     = '0;
        c.cmd = CMD_SPAWN;
        c.pos = {pz, py, px};
        c.vel = {vz, vy, vx};
        send_command(c);
    endtask

    task automatic send_tick(input logic [31:0] ground);
        t_projectile_cmd c;
        c        = '0;
        c.cmd    = CMD_TICK;
        c.ground = ground;
        send_command(c);
    endtask

    task automatic send_contact(input logic [15:0] nx, input logic [15:0] ny,
                                input logic [15:0] nz, input logic solid);
        t_projectile_cmd c;
        c       = '0;
        c.cmd   = CMD_CONTACT;
        c.nrm   = {nz, ny, nx};
        c.solid = solid;
        send_command(c);
    endtask

    // Stops sending and waits until the core has returned every result and
    // has had time to settle, so that registers may be written.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_steps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive edges, budget first. Called only while idle.
    task automatic set_config(input logic [BUDGET_W-1:0] budget,
                              input logic [GRAV_W-1:0] grav);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BUDGET;
        i_cfg_data <= {{(GRAV_W-BUDGET_W){1'b0}}, budget};
        @(posedge i_clk);
        budget_reg  = budget;
        i_cfg_idx  <= CFG_GRAV;
        i_cfg_data <= grav;
        @(posedge i_clk);
        grav_step  = grav;
        i_cfg_we  <= 1'b0;
    endtask

    // Result side: random backpressure and the field by field comparison.
    always @(posedge i_clk) begin : result_check
        t_step_result want;
        t_step_result got;
        int           i;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_cnt++;
            got.pos    = m_axis_tdata[95:0];
            got.vel    = m_axis_tdata[191:96];
            got.imp    = m_axis_tdata[287:192];
            got.status = m_axis_tuser;
            if (expected_steps.size() == 0) begin
                $error("result transaction with no command outstanding");
                mismatch_cnt++;
            end else begin
                want = expected_steps.pop_front();
                for (i = 0; i < 3; i++) begin
                    if (got.pos[i] !== want.pos[i]) begin
                        $error("out_pos_%c: expected %0d, actual %0d", 8'(120 + i),
                               $signed(want.pos[i]), $signed(got.pos[i]));
                        mismatch_cnt++;
                    end
                    if (got.vel[i] !== want.vel[i]) begin
                        $error("out_vel_%c: expected %0d, actual %0d", 8'(120 + i),
                               $signed(want.vel[i]), $signed(got.vel[i]));
                        mismatch_cnt++;
                    end
                    if (got.imp[i] !== want.imp[i]) begin
                        $error("impulse_%c: expected %0d, actual %0d", 8'(120 + i),
                               $signed(want.imp[i]), $signed(got.imp[i]));
                        mismatch_cnt++;
                    end
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatch_cnt++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Straight after reset: commands against the all-zero projectile, including
    // a bounce with the counter already at zero, which wraps and does not expire.
    task automatic test_reset_state();
        send_tick(32'd0);        // velocity picks up gravity, no bounce yet
        send_tick(32'd0);        // falls below ground: bounce with wrapped counter
        send_command('{solid: 1'b1, nrm: '1, ground: '1, vel: '1, pos: '1,
                       cmd: CMD_UNUSED});
        send_contact(16'h0000, 16'hf000, 16'h0000, 1'b0);   // not solid
        send_contact(16'h0000, 16'hf000, 16'h0000, 1'b1);   // moving away: no change
        send_contact(16'h0000, 16'h1000, 16'h0000, 1'b1);   // head-on: impulse
    endtask

    // Spawn at the word corners and bounce until the budget runs out.
    task automatic test_bounce_counter();
        send_spawn(32'h7fff_ffff, 32'd0, 32'h8000_0000,
                   32'h7fff_ffff, 32'd100, 32'h8000_0000);
        repeat (4) send_tick(32'h8000_0000);
        // Height and velocity both wrap negative: no bounce.
        send_spawn(32'd0, 32'h7fff_ffff, 32'hffff_ffff,
                   32'hffff_ffff, 32'h7fff_ffff, 32'd1);
        send_tick(32'h7fff_ffff);
        // Rising projectile stays rising after gravity: no bounce.
        send_spawn(32'd5, 32'd10, 32'd15, 32'd0, -32'sd1000, 32'd0);
        send_tick(32'h8000_0000);
    endtask

    // Contacts with products that overflow, an axis-aligned reflection and a
    // zero normal.
    task automatic test_contact_impulse();
        send_spawn(32'd0, 32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd12345);
        send_contact(16'h8000, 16'h7fff, 16'h8000, 1'b1);
        send_contact(16'h7fff, 16'h8000, 16'h7fff, 1'b1);
        send_spawn(32'd1, 32'd2, 32'd3, -32'sd300, 32'd500, 32'd77);
        send_contact(16'h1000, 16'h0000, 16'h0000, 1'b1);
        send_contact(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_contact(16'h8000, 16'h8000, 16'h8000, 1'b0);
    endtask

    // Random commands in phases, each with its own register setting and its
    // own idle and stall pattern. Extremes of both registers come first.
    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    set_config(7'd1, 12'd4095);
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    set_config(7'd127, 12'd0);
                    src_idle_pct  = 82;
                    snk_stall_pct = 0;
                end
                2: begin
                    set_config(BUDGET_W'($urandom_range(1, 127)),
                               GRAV_W'($urandom_range(4095)));
                    src_idle_pct  = 0;
                    snk_stall_pct = 82;
                end
                3: begin
                    set_config(BUDGET_W'($urandom_range(1, 127)),
                               GRAV_W'($urandom_range(4095)));
                    src_idle_pct  = 17;
                    snk_stall_pct = 17;
                end
                default: begin
                    set_config(BUDGET_RST, GRAV_RST);
                    src_idle_pct  = $urandom_range(1) * 17;
                    snk_stall_pct = $urandom_range(1) * 17;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_command(random_command());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_BUDGET;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_TICK;
        m_axis_tready <= 1'b1;
        proj_pos      = '0;
        proj_vel      = '0;
        bounces_left  = 8'd0;
        budget_reg    = BUDGET_RST;
        grav_step     = GRAV_RST;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        mismatch_cnt  = 0;
        sent_cnt      = 0;
        result_cnt    = 0;
        bounce_cnt    = 0;
        expire_cnt    = 0;
        impulse_cnt   = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_bounce_counter();
        test_contact_impulse();
        test_random_traffic();
        wait_idle();

        $display("summary: %0d commands sent, %0d results checked, %0d mismatches",
                 sent_cnt, result_cnt, mismatch_cnt);
        $display("summary: %0d bounces, %0d expiries, %0d impulses over 5 settings",
                 bounce_cnt, expire_cnt, impulse_cnt);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/pgbs_pkg.sv
rtl/core/projectile_gravity_bounce_step_core.sv
tb/tb_top.sv
